// File: sv/toi_pkg.sv
// Package for the 2-opt tour improver: widths, kinds, state encoding.
// No dependencies.
`timescale 1ns / 1ps
package toi_pkg;
  localparam int unsigned MaxCities = 64;
  localparam int unsigned DistBits  = 24;
  localparam int unsigned PassLimit = 256;
  localparam int unsigned IdxW      = 6;
  localparam int unsigned CntW      = 7;
  localparam int unsigned InDistW   = 24;

  typedef enum logic [1:0] {
    KIND_DIST = 2'd0,
    KIND_TOUR = 2'd1,
    KIND_RUN  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_AB, ST_RD_CE, ST_D0, ST_D1, ST_D2, ST_D3, ST_CMP,
    ST_REV_RD, ST_REV_WR, ST_NEXT, ST_OUT_RD, ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [IdxW-1:0]    row_index;
    logic [IdxW-1:0]    column_index;
    logic [InDistW-1:0] distance_value;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0] position;
    logic [IdxW-1:0] city;
    logic            last;
  } out_word_t;
endpackage

// File: sv/toi_if.sv
// Valid/ready channel interface carrying one word.
// Depends on toi_pkg.
`timescale 1ns / 1ps
interface toi_in_if;
  logic               valid;
  logic               ready;
  toi_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface toi_out_if;
  logic               valid;
  logic               ready;
  toi_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/toi_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module toi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// File: sv/two_opt_tour_improver.sv
// Two-opt tour improver: distance and tour memories plus a search sequencer.
// Load words are accepted while idle. A run word compares each (i,j) pair and, on an
// improvement, reverses the segment between them pair by pair, pass after pass, up to 256
// passes, then emits n output words. Input is stalled for the whole run.
// Reset (async, active low) clears control state and city_count; memories
// hold undefined contents until loaded.
`timescale 1ns / 1ps
module two_opt_tour_improver #(
  parameter int unsigned MAX_CITIES = toi_pkg::MaxCities,
  parameter int unsigned DIST_BITS  = toi_pkg::DistBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [toi_pkg::CntW-1:0] cfg_wdata_i,
  toi_in_if.sink                  in_i,
  toi_out_if.source               out_o
);
  localparam int unsigned CW = $clog2(MAX_CITIES);
  localparam int unsigned NW = CW + 1;
  localparam int unsigned AW = 2 * CW;
  localparam int unsigned Lim = (MAX_CITIES < 64) ? MAX_CITIES : 64;
  localparam int unsigned LW = $clog2(Lim + 1);

  toi_pkg::state_e state_q, state_d;
  logic [toi_pkg::CntW-1:0] cnt_q;
  logic [NW-1:0] n_q, n_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0] a_q, a_d, b_q, b_d, c_q, c_d, e_q, e_d;
  logic [DIST_BITS:0] old_q, old_d, new_q, new_d;
  logic [DIST_BITS-1:0] dt_q, dt_d;
  logic [8:0] pass_q, pass_d;
  logic imp_q, imp_d;
  logic [CW-1:0] ov_q, ov_d;

  logic          d_we, t_we;
  logic [AW-1:0] d_addr;
  logic [DIST_BITS-1:0] d_wdata, d_rdata;
  logic [CW-1:0] t_addr, t_wdata, t_rdata;

  toi_ram #(.Width(DIST_BITS), .Depth(1 << AW)) u_dist (
    .clk_i, .we_i(d_we), .addr_i(d_addr), .wdata_i(d_wdata), .rdata_o(d_rdata));
  toi_ram #(.Width(CW), .Depth(MAX_CITIES)) u_tour (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(t_wdata), .rdata_o(t_rdata));

  logic [LW-1:0] lim_cnt;
  logic [NW-1:0] n_act;
  logic [6:0] row_ext, col_ext;
  logic in_rng_r, in_rng_c;
  // tour read sub-sequence within ST_RD_AB, and the reversal steps in ST_REV_RD/ST_NEXT, use a small counter
  logic [1:0] sub_q, sub_d;

  always_comb begin
    lim_cnt = (cnt_q > toi_pkg::CntW'(Lim)) ? LW'(Lim) : LW'(cnt_q);
    n_act = NW'(lim_cnt);
    row_ext = 7'(in_i.data.row_index);
    col_ext = 7'(in_i.data.column_index);
    in_rng_r = 32'(row_ext) < MAX_CITIES;
    in_rng_c = 32'(col_ext) < MAX_CITIES;
  end

  function automatic logic [CW-1:0] nxt(input logic [CW-1:0] x, input logic [NW-1:0] n);
    logic [NW-1:0] y;
    y = NW'(x) + NW'(1);
    nxt = (y == n) ? '0 : CW'(y);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= toi_pkg::ST_IDLE;
      cnt_q <= '0;
      imp_q <= 1'b0;
    end else begin
      state_q <= state_d;
      imp_q <= imp_d;
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; i_q <= i_d; j_q <= j_d; lo_q <= lo_d; hi_q <= hi_d;
    a_q <= a_d; b_q <= b_d; c_q <= c_d; e_q <= e_d;
    old_q <= old_d; new_q <= new_d; dt_q <= dt_d; pass_q <= pass_d;
    ov_q <= ov_d; sub_q <= sub_d;
  end

  always_comb begin
    state_d = state_q;
    n_d = n_q; i_d = i_q; j_d = j_q; lo_d = lo_q; hi_d = hi_q;
    a_d = a_q; b_d = b_q; c_d = c_q; e_d = e_q;
    old_d = old_q; new_d = new_q; dt_d = dt_q; pass_d = pass_q;
    imp_d = imp_q; ov_d = ov_q; sub_d = sub_q;
    d_we = 1'b0; d_addr = '0; d_wdata = '0;
    t_we = 1'b0; t_addr = '0; t_wdata = '0;
    in_i.ready = 1'b0;
    out_o.valid = 1'b0;
    out_o.data.position = 6'(ov_q);
    out_o.data.city = 6'(t_rdata);
    out_o.data.last = (NW'(ov_q) + NW'(1)) == n_q;
    unique case (state_q)
      toi_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        d_addr = {CW'(in_i.data.row_index), CW'(in_i.data.column_index)};
        d_wdata = DIST_BITS'(in_i.data.distance_value);
        t_addr = CW'(in_i.data.row_index);
        t_wdata = CW'(in_i.data.column_index);
        if (in_i.valid) begin
          unique case (toi_pkg::kind_e'(in_i.data.kind))
            toi_pkg::KIND_DIST: d_we = in_rng_r && in_rng_c;
            toi_pkg::KIND_TOUR: t_we = in_rng_r;
            toi_pkg::KIND_RUN: begin
              n_d = n_act;
              ov_d = '0;
              pass_d = '0;
              i_d = CW'(1); j_d = CW'(2); sub_d = '0;
              imp_d = 1'b0;
              if (n_act >= NW'(4)) state_d = toi_pkg::ST_RD_AB;
              else if (n_act != '0) state_d = toi_pkg::ST_OUT_RD;
            end
            default: ;
          endcase
        end
      end
      // reads a,b,c,e one per cycle (sub 0..3 issue the reads; a,b,c latch at sub 1..3, e in ST_RD_CE)
      toi_pkg::ST_RD_AB: begin
        unique case (sub_q)
          2'd0: t_addr = i_q - CW'(1);
          2'd1: t_addr = i_q;
          2'd2: t_addr = j_q;
          default: t_addr = nxt(j_q, n_q);
        endcase
        if (sub_q == 2'd1) a_d = t_rdata;
        if (sub_q == 2'd2) b_d = t_rdata;
        if (sub_q == 2'd3) c_d = t_rdata;
        sub_d = sub_q + 2'd1;
        if (sub_q == 2'd3) state_d = toi_pkg::ST_RD_CE;
      end
      toi_pkg::ST_RD_CE: begin
        e_d = t_rdata;
        d_addr = {a_q, b_q};
        state_d = toi_pkg::ST_D0;
      end
      toi_pkg::ST_D0: begin
        d_addr = {c_q, e_q};
        dt_d = d_rdata;
        state_d = toi_pkg::ST_D1;
      end
      toi_pkg::ST_D1: begin
        d_addr = {a_q, c_q};
        old_d = {1'b0, dt_q} + {1'b0, d_rdata};
        state_d = toi_pkg::ST_D2;
      end
      toi_pkg::ST_D2: begin
        d_addr = {b_q, e_q};
        dt_d = d_rdata;
        state_d = toi_pkg::ST_D3;
      end
      toi_pkg::ST_D3: begin
        new_d = {1'b0, dt_q} + {1'b0, d_rdata};
        state_d = toi_pkg::ST_CMP;
      end
      toi_pkg::ST_CMP: begin
        lo_d = i_q; hi_d = j_q;
        if (new_q < old_q) begin
          imp_d = 1'b1;
          state_d = toi_pkg::ST_REV_RD;
          t_addr = i_q;
        end else state_d = toi_pkg::ST_NEXT;
      end
      // sub 1: issue read of tour[lo], or finish when lo >= hi; sub 0: latch tour[lo] into b, read tour[hi]
      toi_pkg::ST_REV_RD: begin
        if (sub_q == 2'd1) begin
          t_addr = lo_q;
          sub_d = '0;
          if (lo_q >= hi_q) state_d = toi_pkg::ST_NEXT;
        end else begin
          b_d = t_rdata;
          t_addr = hi_q;
          state_d = toi_pkg::ST_REV_WR;
        end
      end
      toi_pkg::ST_REV_WR: begin
        t_we = 1'b1;
        t_addr = lo_q;
        t_wdata = t_rdata;
        c_d = t_rdata;
        state_d = toi_pkg::ST_NEXT;
        sub_d = 2'd2;
      end
      toi_pkg::ST_NEXT: begin
        if (sub_q == 2'd2) begin
          t_we = 1'b1;
          t_addr = hi_q;
          t_wdata = b_q;
          lo_d = lo_q + CW'(1);
          hi_d = hi_q - CW'(1);
          sub_d = 2'd1;
          state_d = toi_pkg::ST_REV_RD;
        end else begin
          sub_d = '0;
          state_d = toi_pkg::ST_RD_AB;
          if (NW'(j_q) + NW'(1) < n_q) j_d = j_q + CW'(1);
          else if (NW'(i_q) + NW'(2) < n_q) begin
            i_d = i_q + CW'(1);
            j_d = i_q + CW'(2);
          end else begin
            i_d = CW'(1); j_d = CW'(2);
            pass_d = pass_q + 9'd1;
            imp_d = 1'b0;
            if (!imp_q || pass_q + 9'd1 >= 9'(toi_pkg::PassLimit))
              state_d = toi_pkg::ST_OUT_RD;
          end
        end
      end
      toi_pkg::ST_OUT_RD: begin
        t_addr = ov_q;
        state_d = toi_pkg::ST_OUT;
      end
      toi_pkg::ST_OUT: begin
        out_o.valid = 1'b1;
        t_addr = ov_q;
        if (out_o.ready) begin
          ov_d = ov_q + CW'(1);
          if (out_o.data.last) state_d = toi_pkg::ST_IDLE;
          else state_d = toi_pkg::ST_OUT_RD;
        end
      end
      default: state_d = toi_pkg::ST_IDLE;
    endcase
  end
endmodule

// File: sv/toi_checker.sv
// Port-level checker for the two-opt tour improver, bound to the top level.
// Depends on the top level.
`timescale 1ns / 1ps
module toi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [5:0] out_pos
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input open during read-out");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pos))
    else $error("output word dropped");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("word after last");
endmodule

bind two_opt_tour_improver toi_checker u_toi_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .out_last(out_o.data.last), .out_pos(out_o.data.position));

// File: bench/tb_top.sv
// Self-checking bench for two_opt_tour_improver: directed table, then random load/run phases.
// An internal 2-opt predictor computes the expected words of the random phases; the directed table lists its own.
// Depends on toi_pkg, toi_if.sv and the two_opt_tour_improver RTL.
`timescale 1ns / 1ps
module tb_top;
  typedef enum logic [1:0] {OP_CFG, OP_WORD} op_e;

  typedef struct {
    op_e             op;
    toi_pkg::kind_e  kind;
    int unsigned     row;
    int unsigned     col;
    int unsigned     val;
    int unsigned     n_out;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [toi_pkg::CntW-1:0] cfg_wdata;

  toi_in_if  in_if();
  toi_out_if out_if();

  two_opt_tour_improver u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // predictor state
  logic [toi_pkg::DistBits-1:0] dist_m [toi_pkg::MaxCities][toi_pkg::MaxCities];
  logic [toi_pkg::IdxW-1:0]     tour_m [toi_pkg::MaxCities];
  int unsigned                  city_cnt;
  toi_pkg::out_word_t           tour_out_q[$];
  int unsigned                  mismatches;
  int unsigned                  burst_left;
  int unsigned                  stall_mode;
  int unsigned                  stall_left;

  dir_row_t           dir_tab[18];
  toi_pkg::out_word_t dir_exp[$];

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    #5s;
    $display("two_opt_tour_improver test failed");
    $finish;
  end

  function automatic int unsigned active_n();
    return (city_cnt > toi_pkg::MaxCities) ? toi_pkg::MaxCities : city_cnt;
  endfunction

  function automatic void two_opt_search(int unsigned n);
    bit          changed;
    int unsigned pass;
    int unsigned nj;
    logic [toi_pkg::DistBits:0] old_sum;
    logic [toi_pkg::DistBits:0] new_sum;
    logic [toi_pkg::IdxW-1:0]   a, b, c, e, t;
    int unsigned lo, hi;
    changed = 1'b1;
    pass = 0;
    while (changed && pass < toi_pkg::PassLimit) begin
      changed = 1'b0;
      pass++;
      for (int unsigned i = 1; i + 1 < n; i++) begin
        for (int unsigned j = i + 1; j < n; j++) begin
          nj = (j + 1 == n) ? 0 : j + 1;
          a = tour_m[i-1];
          b = tour_m[i];
          c = tour_m[j];
          e = tour_m[nj];
          old_sum = dist_m[a][b] + dist_m[c][e];
          new_sum = dist_m[a][c] + dist_m[b][e];
          if (new_sum < old_sum) begin
            lo = i;
            hi = j;
            while (lo < hi) begin
              t = tour_m[lo];
              tour_m[lo] = tour_m[hi];
              tour_m[hi] = t;
              lo++;
              hi--;
            end
            changed = 1'b1;
          end
        end
      end
    end
  endfunction

  function automatic void apply_word(toi_pkg::in_word_t w, bit typed, int unsigned n_out);
    int unsigned        n;
    toi_pkg::out_word_t o;
    case (toi_pkg::kind_e'(w.kind))
      toi_pkg::KIND_DIST: begin
        dist_m[w.row_index][w.column_index] = w.distance_value;
      end
      toi_pkg::KIND_TOUR: begin
        tour_m[w.row_index] = w.column_index;
      end
      toi_pkg::KIND_RUN: begin
        if (typed) begin
          repeat (n_out) begin
            o = dir_exp.pop_front();
            tour_out_q = {tour_out_q, o};
          end
        end else begin
          n = active_n();
          if (n >= 4) two_opt_search(n);
          for (int unsigned k = 0; k < n; k++) begin
            o.position = k[toi_pkg::IdxW-1:0];
            o.city     = tour_m[k];
            o.last     = (k + 1 == n);
            tour_out_q = {tour_out_q, o};
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic post_word(toi_pkg::kind_e kind, int unsigned row, int unsigned col,
                           int unsigned val, bit typed = 1'b0,
                           int unsigned n_out = 0);
    toi_pkg::in_word_t w;
    w.kind           = kind;
    w.row_index      = row[toi_pkg::IdxW-1:0];
    w.column_index   = col[toi_pkg::IdxW-1:0];
    w.distance_value = val[toi_pkg::InDistW-1:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    apply_word(w, typed, n_out);
  endtask

  task automatic write_count(int unsigned val);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tour_out_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= val[toi_pkg::CntW-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    city_cnt = val;
    burst_left = 0;
  endtask

  function automatic int unsigned rand_dist();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 24'hFFFFFF;
      2, 3:    return $urandom_range(0, 15);
      default: return $urandom() & 24'hFFFFFF;
    endcase
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0)
      post_word(toi_pkg::KIND_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                $urandom() & 24'hFFFFFF);
  endtask

  // One phase: set count, load tour over span cities (all distinct when span is 0),
  // load the matrix over those cities if n is at least 4, run, and maybe rerun.
  task automatic run_phase(int unsigned cfg_val, bit sym, int unsigned span);
    int unsigned pool[64];
    int unsigned n, m, k, t, v;
    n = (cfg_val > toi_pkg::MaxCities) ? toi_pkg::MaxCities : cfg_val;
    m = (span == 0) ? n : span;
    write_count(cfg_val);
    for (int i = 0; i < 64; i++) pool[i] = i;
    for (int i = 63; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[k];
      pool[k] = t;
    end
    for (int i = 0; i < n; i++) begin
      maybe_noise();
      k = (span == 0) ? i : $urandom_range(0, span - 1);
      post_word(toi_pkg::KIND_TOUR, i, pool[k], $urandom() & 24'hFFFFFF);
    end
    if (n >= 4) begin
      for (int r = 0; r < m; r++) begin
        for (int c = 0; c < m; c++) begin
          if (sym && c < r) v = dist_m[pool[c]][pool[r]];
          else v = rand_dist();
          if (r == c && sym) v = 0;
          post_word(toi_pkg::KIND_DIST, pool[r], pool[c], v);
        end
      end
    end
    post_word(toi_pkg::KIND_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom() & 24'hFFFFFF);
    // rerun on the same data after some distance rewrites
    if (n >= 4 && n <= 12 && $urandom_range(0, 1)) begin
      repeat ($urandom_range(1, 4)) begin
        maybe_noise();
        post_word(toi_pkg::KIND_DIST, pool[$urandom_range(0, m - 1)],
                  pool[$urandom_range(0, m - 1)], rand_dist());
      end
      post_word(toi_pkg::KIND_RUN, 0, 0, 0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_mode   <= 0;
      stall_left   <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_left <= $urandom_range(8, 80);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 9) < 7);
        default: out_if.ready <= (stall_left[1:0] != 2'd3) && (stall_left[4:2] != 3'd5);
      endcase
    end
  end

  always @(posedge clk_i) begin
    toi_pkg::out_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (tour_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pos %0d city %0d last %0b",
                   out_if.data.position, out_if.data.city, out_if.data.last);
      end else begin
        exp_w = tour_out_q.pop_front();
        if (out_if.data.position !== exp_w.position || out_if.data.city !== exp_w.city ||
            out_if.data.last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pos %0d city %0d last %0b, got pos %0d city %0d last %0b",
                     exp_w.position, exp_w.city, exp_w.last, out_if.data.position,
                     out_if.data.city, out_if.data.last);
        end
      end
    end
  end

  initial begin
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_ni      <= 1'b0;
    mismatches  = 0;
    burst_left  = 0;
    city_cnt    = 0;

    dir_tab = '{
      '{OP_CFG,  toi_pkg::KIND_NONE, 0,  0,  0,           0},
      '{OP_WORD, toi_pkg::KIND_RUN,  0,  0,  0,           0},
      '{OP_CFG,  toi_pkg::KIND_NONE, 0,  0,  3,           0},
      '{OP_WORD, toi_pkg::KIND_TOUR, 0,  63, 24'hFFFFFF,  0},
      '{OP_WORD, toi_pkg::KIND_TOUR, 1,  0,  0,           0},
      '{OP_WORD, toi_pkg::KIND_TOUR, 2,  21, 0,           0},
      '{OP_WORD, toi_pkg::KIND_NONE, 63, 63, 24'hFFFFFF,  0},
      '{OP_WORD, toi_pkg::KIND_RUN,  63, 63, 24'hFFFFFF,  3},
      '{OP_CFG,  toi_pkg::KIND_NONE, 0,  0,  1,           0},
      '{OP_WORD, toi_pkg::KIND_RUN,  0,  0,  0,           1},
      '{OP_CFG,  toi_pkg::KIND_NONE, 0,  0,  4,           0},
      '{OP_WORD, toi_pkg::KIND_TOUR, 0,  0,  0,           0},
      '{OP_WORD, toi_pkg::KIND_TOUR, 3,  0,  0,           0},
      '{OP_WORD, toi_pkg::KIND_TOUR, 2,  0,  0,           0},
      '{OP_WORD, toi_pkg::KIND_DIST, 0,  0,  24'hFFFFFF,  0},
      '{OP_WORD, toi_pkg::KIND_RUN,  0,  0,  0,           4},
      '{OP_WORD, toi_pkg::KIND_DIST, 0,  0,  0,           0},
      '{OP_WORD, toi_pkg::KIND_RUN,  0,  0,  0,           4}
    };
    dir_exp = '{
      '{6'd0, 6'd63, 1'b0}, '{6'd1, 6'd0, 1'b0}, '{6'd2, 6'd21, 1'b1},
      '{6'd0, 6'd63, 1'b1},
      '{6'd0, 6'd0, 1'b0}, '{6'd1, 6'd0, 1'b0}, '{6'd2, 6'd0, 1'b0}, '{6'd3, 6'd0, 1'b1},
      '{6'd0, 6'd0, 1'b0}, '{6'd1, 6'd0, 1'b0}, '{6'd2, 6'd0, 1'b0}, '{6'd3, 6'd0, 1'b1}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].op == OP_CFG)
        write_count(dir_tab[r].val);
      else
        post_word(dir_tab[r].kind, dir_tab[r].row, dir_tab[r].col, dir_tab[r].val,
                  dir_tab[r].kind == toi_pkg::KIND_RUN, dir_tab[r].n_out);
    end

    // full-size tour over three cities, symmetric so the search settles
    run_phase(($urandom_range(0, 1) != 0) ? 127 : 64, 1'b1, 3);
    run_phase($urandom_range(4, 5), $urandom_range(0, 1), 0);

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tour_out_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("two_opt_tour_improver test passed");
    end else begin
      $display("two_opt_tour_improver test failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/toi_pkg.sv
sv/toi_if.sv
sv/toi_ram.sv
sv/two_opt_tour_improver.sv
sv/toi_checker.sv
bench/tb_top.sv
